// ----- rtl/core/sftr_pkg.sv -----
// sftr_pkg: sizes, word types and state codes for the sample framer tx ring
// used by sample_framer_tx_ring_top; no dependencies
package sftr_pkg;

  localparam int RING_DEPTH  = 512;
  localparam int FRAME_LEN   = 64;
  localparam int STAGE_BYTES = 2 * FRAME_LEN;

  localparam int RingAw  = $clog2(RING_DEPTH);
  localparam int UsedW   = RingAw + 1;
  localparam int StageAw = $clog2(STAGE_BYTES);
  localparam int SampW   = $clog2(FRAME_LEN + 1);
  localparam int CopyW   = $clog2(STAGE_BYTES + 1);

  localparam int SampleW = 12;
  localparam int FreeW   = 9;
  localparam int CountW  = 32;

  localparam logic [7:0] LO_MASK = 8'hFF;
  localparam logic [7:0] HI_MASK = 8'h0F;

  typedef enum logic {
    FUNC_SAMPLE = 1'b0,
    FUNC_POP    = 1'b1
  } func_t;

  typedef struct packed {
    logic               func;
    logic [SampleW-1:0] sample_value;
  } in_word_t;

  typedef struct packed {
    logic              byte_valid;
    logic [7:0]        tx_byte;
    logic              frame_closed;
    logic              frame_queued;
    logic              frame_dropped;
    logic              ring_empty;
    logic [FreeW-1:0]  free_space;
    logic [CountW-1:0] queued_total;
    logic [CountW-1:0] dropped_total;
  } out_word_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_HI    = 6'b000010,
    S_CHECK = 6'b000100,
    S_COPY  = 6'b001000,
    S_POP   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

endpackage

// ----- rtl/core/sample_framer_tx_ring_top.sv -----
// sample_framer_tx_ring_top: stages 12-bit samples as byte frames, admits whole
// frames into a byte ring, pops one byte per transmitter poll; uses sftr_pkg
//
//   channel | ports                          | carries
//   input   | in_valid, in_stall, in_data    | sample or transmitter poll word
//   result  | out_valid, out_stall, out_data | one status word per input word
//
// a sample that closes a frame and is admitted passes through the copy unit,
// which moves one byte per cycle from the stage memory's read port to the
// ring memory's write port
// no clearing pass after reset: pointers and counters reset, memories do not
// the result register lets the next word be accepted while one waits; a word
// that finishes while the previous result is still stalled holds in S_DONE
module sample_framer_tx_ring_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sftr_pkg::in_word_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output sftr_pkg::out_word_t out_data
);
  import sftr_pkg::*;

  state_t state_r, state_nxt;

  logic [RingAw-1:0] wp_r, wp_nxt;
  logic [RingAw-1:0] rp_r, rp_nxt;
  logic [SampW-1:0]  cnt_r, cnt_nxt;
  logic [CountW-1:0] queued_cnt_r, queued_cnt_nxt;
  logic [CountW-1:0] dropped_cnt_r, dropped_cnt_nxt;
  logic [CopyW-1:0]  copy_cnt_r, copy_cnt_nxt;
  logic              wr_pend_r, wr_pend_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [SampleW-1:0] sample_r, sample_nxt;
  logic               byte_valid_r, byte_valid_nxt;
  logic [7:0]         tx_byte_r, tx_byte_nxt;
  logic               closed_r, closed_nxt;
  logic               queued_r, queued_nxt;
  logic               dropped_r, dropped_nxt;
  out_word_t          out_data_r, out_data_nxt;

  logic [7:0] stage_mem [STAGE_BYTES];
  logic [7:0] ring_mem  [RING_DEPTH];
  logic [7:0] stage_q_r;
  logic [7:0] ring_q_r;

  logic               stage_we;
  logic [StageAw-1:0] stage_wa;
  logic [7:0]         stage_wd;
  logic               ring_we;

  logic               accept;
  logic               can_load;
  logic [UsedW-1:0]   used;
  logic [UsedW-1:0]   free_cnt;
  logic [31:0]        free32;
  logic [RingAw-1:0]  wp_inc, rp_inc;
  logic [SampW-1:0]   cnt_inc;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign can_load  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ring occupancy, wraps for any depth
  always_comb begin
    used = {1'b0, wp_r} - {1'b0, rp_r};
    if (wp_r < rp_r) begin
      used = used + UsedW'(RING_DEPTH);
    end
    free_cnt = UsedW'(RING_DEPTH - 1) - used;
    free32   = 32'(free_cnt);
  end

  assign wp_inc  = (wp_r == RingAw'(RING_DEPTH - 1)) ? '0 : wp_r + 1'b1;
  assign rp_inc  = (rp_r == RingAw'(RING_DEPTH - 1)) ? '0 : rp_r + 1'b1;
  assign cnt_inc = cnt_r + 1'b1;

  always_comb begin
    state_nxt       = state_r;
    wp_nxt          = wp_r;
    rp_nxt          = rp_r;
    cnt_nxt         = cnt_r;
    queued_cnt_nxt  = queued_cnt_r;
    dropped_cnt_nxt = dropped_cnt_r;
    copy_cnt_nxt    = copy_cnt_r;
    wr_pend_nxt     = 1'b0;
    out_valid_nxt   = out_valid_r && out_stall;
    sample_nxt      = sample_r;
    byte_valid_nxt  = byte_valid_r;
    tx_byte_nxt     = tx_byte_r;
    closed_nxt      = closed_r;
    queued_nxt      = queued_r;
    dropped_nxt     = dropped_r;
    out_data_nxt    = out_data_r;
    stage_we        = 1'b0;
    stage_wa        = StageAw'({cnt_r, 1'b0});
    stage_wd        = in_data.sample_value[7:0] & LO_MASK;
    ring_we         = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          byte_valid_nxt = 1'b0;
          tx_byte_nxt    = '0;
          closed_nxt     = 1'b0;
          queued_nxt     = 1'b0;
          dropped_nxt    = 1'b0;
          sample_nxt     = in_data.sample_value;
          if (in_data.func == FUNC_POP) begin
            state_nxt = S_POP;
          end else begin
            // low byte goes in right away
            stage_we  = 1'b1;
            state_nxt = S_HI;
          end
        end
      end
      S_HI: begin
        stage_we = 1'b1;
        stage_wa = StageAw'({cnt_r, 1'b1});
        stage_wd = {4'b0, sample_r[SampleW-1:8]} & HI_MASK;
        if (cnt_inc == SampW'(FRAME_LEN)) begin
          cnt_nxt    = '0;
          closed_nxt = 1'b1;
          state_nxt  = S_CHECK;
        end else begin
          cnt_nxt   = cnt_inc;
          state_nxt = S_DONE;
        end
      end
      S_CHECK: begin
        copy_cnt_nxt = '0;
        if (free32 >= 32'(STAGE_BYTES)) begin
          queued_nxt     = 1'b1;
          queued_cnt_nxt = queued_cnt_r + 1'b1;
          state_nxt      = S_COPY;
        end else begin
          dropped_nxt     = 1'b1;
          dropped_cnt_nxt = dropped_cnt_r + 1'b1;
          state_nxt       = S_DONE;
        end
      end
      S_COPY: begin
        // read stage byte k while byte k-1 lands in the ring
        if (wr_pend_r) begin
          ring_we = 1'b1;
          wp_nxt  = wp_inc;
        end
        if (copy_cnt_r == CopyW'(STAGE_BYTES)) begin
          state_nxt = S_DONE;
        end else begin
          wr_pend_nxt  = 1'b1;
          copy_cnt_nxt = copy_cnt_r + 1'b1;
        end
      end
      S_POP: begin
        if (rp_r != wp_r) begin
          byte_valid_nxt = 1'b1;
          tx_byte_nxt    = ring_q_r;
          rp_nxt         = rp_inc;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (can_load) begin
          out_data_nxt.byte_valid    = byte_valid_r;
          out_data_nxt.tx_byte       = tx_byte_r;
          out_data_nxt.frame_closed  = closed_r;
          out_data_nxt.frame_queued  = queued_r;
          out_data_nxt.frame_dropped = dropped_r;
          out_data_nxt.ring_empty    = (rp_r == wp_r);
          out_data_nxt.free_space    = free32[FreeW-1:0];
          out_data_nxt.queued_total  = queued_cnt_r;
          out_data_nxt.dropped_total = dropped_cnt_r;
          out_valid_nxt              = 1'b1;
          state_nxt                  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      wp_r          <= '0;
      rp_r          <= '0;
      cnt_r         <= '0;
      queued_cnt_r  <= '0;
      dropped_cnt_r <= '0;
      copy_cnt_r    <= '0;
      wr_pend_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      wp_r          <= wp_nxt;
      rp_r          <= rp_nxt;
      cnt_r         <= cnt_nxt;
      queued_cnt_r  <= queued_cnt_nxt;
      dropped_cnt_r <= dropped_cnt_nxt;
      copy_cnt_r    <= copy_cnt_nxt;
      wr_pend_r     <= wr_pend_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r     <= sample_nxt;
    byte_valid_r <= byte_valid_nxt;
    tx_byte_r    <= tx_byte_nxt;
    closed_r     <= closed_nxt;
    queued_r     <= queued_nxt;
    dropped_r    <= dropped_nxt;
    out_data_r   <= out_data_nxt;
  end

  // stage memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (stage_we) begin
      stage_mem[stage_wa] <= stage_wd;
    end
    stage_q_r <= stage_mem[copy_cnt_r[StageAw-1:0]];
  end

  // ring memory: written at the write pointer, read at the read pointer
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[wp_r] <= stage_q_r;
    end
    ring_q_r <= ring_mem[rp_r];
  end

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.frame_queued || out_data_r.frame_dropped) |->
      out_data_r.frame_closed && !(out_data_r.frame_queued && out_data_r.frame_dropped))
    else $error("frame flags inconsistent");

  a_pop_no_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.byte_valid |-> !out_data_r.frame_closed)
    else $error("popped byte reported with frame close");

  a_copy_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_COPY |-> copy_cnt_r <= CopyW'(STAGE_BYTES))
    else $error("copy count past frame length");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != S_IDLE)
    else $error("accepted word not processed");

endmodule
